### design/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types, constants and boolean matrix helpers for the morphism code
// filter: code layout, incidence matrix type and per-item result struct.
// ----------------------------------------------------------------------------
package mcf_pkg;

    // Code layout: four letters, three image letters each, two bits a letter
    localparam int NUM_LETTERS = 4;
    localparam int IMG_LEN     = 3;
    localparam int LETTER_W    = 2;
    localparam int CODE_W      = NUM_LETTERS * IMG_LEN * LETTER_W;

    // Image letter-sum reaches 9, distinct count reaches 4
    localparam int SUM_W   = 4;
    localparam int COUNT_W = 3;

    // Threshold register
    localparam int                 THRESH_W     = 3;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 3'd3;

    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [THRESH_W-1:0] t_thresh;

    // Boolean incidence matrix: row i, bit j set when letter i is in image of j
    typedef logic [NUM_LETTERS-1:0][NUM_LETTERS-1:0] t_mat;

    // Per-item test results from the evaluation logic
    typedef struct packed {
        logic   prolongable;
        t_count distinct_sums;
        logic   primitive_res;
    } t_result;

    // Boolean matrix product, row-mask form: row i of a selects rows of b
    function automatic t_mat mat_mul(input t_mat a, input t_mat b);
        t_mat r;
        r = '0;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            for (int k = 0; k < NUM_LETTERS; k++) begin
                if (a[i][k]) begin
                    r[i] = r[i] | b[k];
                end
            end
        end
        return r;
    endfunction

endpackage

### design/morphism_code_filter_core.sv
// Path: an accepted code is held in the input register, then in the result
// register, which raises result valid.
// Throughput: one code per cycle; a stalled result holds both stages.
// Reset: synchronous, active low; clears both valid flags and loads the
// distinct-sums threshold with 3.
// ----------------------------------------------------------------------------
// morphism_code_filter_core
// Tests 24-bit codes of 3-uniform morphisms on four letters for prolongable,
// distinct image sums and primitivity, and flags codes that pass all three.
// ----------------------------------------------------------------------------
module morphism_code_filter_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Threshold write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  mcf_pkg::t_thresh       i_cfg_min_distinct_sums,

    // Code input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  mcf_pkg::t_code         i_morphism_code,

    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_prolongable,
    output mcf_pkg::t_count        o_distinct_sums,
    output logic                   o_primitive_res,
    output logic                   o_passes_all
);
    import mcf_pkg::*;

    t_thresh r_thresh;
    logic    r_s1_valid;
    t_code   r_code;
    logic    r_out_valid;
    t_result r_result;
    logic    r_passes;

    t_result n_result;
    logic    n_passes;
    logic    out_load;
    logic    s1_load;

    // Threshold register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_min_distinct_sums;
        end
    end

    // Advance when the next stage is empty or drains this cycle
    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign s1_load    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_code <= i_morphism_code;
        end
    end

    // Evaluate the registered code
    mcf_eval u_eval (
        .i_code   (r_code),
        .o_result (n_result)
    );

    // Combine the three tests against the threshold
    assign n_passes = n_result.prolongable && n_result.primitive_res &&
                      (n_result.distinct_sums >= r_thresh);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result <= n_result;
            r_passes <= n_passes;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_prolongable   = r_result.prolongable;
    assign o_distinct_sums = r_result.distinct_sums;
    assign o_primitive_res = r_result.primitive_res;
    assign o_passes_all    = r_passes;

endmodule

### design/mcf_eval.sv
// ----------------------------------------------------------------------------
// mcf_eval
// Combinational tests on one morphism code: prolongable flag, count of
// distinct image letter-sums and primitivity of the incidence matrix.
// ----------------------------------------------------------------------------
module mcf_eval (
    input  mcf_pkg::t_code   i_code,
    output mcf_pkg::t_result o_result
);
    import mcf_pkg::*;

    t_letter img [NUM_LETTERS][IMG_LEN];
    t_sum    sums [NUM_LETTERS];
    t_mat    m1;
    t_mat    m2;
    t_mat    m4;
    t_mat    m8;
    t_mat    m12;
    logic    prol;
    t_count  count;

    // Split the code into image letters
    always_comb begin
        for (int a = 0; a < NUM_LETTERS; a++) begin
            for (int r = 0; r < IMG_LEN; r++) begin
                img[a][r] = i_code[(a*IMG_LEN + r)*LETTER_W +: LETTER_W];
            end
        end
    end

    // Flag a letter whose image begins with itself
    always_comb begin
        prol = 1'b0;
        for (int a = 0; a < NUM_LETTERS; a++) begin
            if (img[a][0] == t_letter'(a)) begin
                prol = 1'b1;
            end
        end
    end

    // Form letter-sums of each image
    always_comb begin
        for (int a = 0; a < NUM_LETTERS; a++) begin
            sums[a] = t_sum'(img[a][0]) + t_sum'(img[a][1]) + t_sum'(img[a][2]);
        end
    end

    // Count a sum only if no earlier letter has the same one
    always_comb begin
        count = t_count'(1);
        if (sums[1] != sums[0]) begin
            count = count + t_count'(1);
        end
        if ((sums[2] != sums[0]) && (sums[2] != sums[1])) begin
            count = count + t_count'(1);
        end
        if ((sums[3] != sums[0]) && (sums[3] != sums[1]) && (sums[3] != sums[2])) begin
            count = count + t_count'(1);
        end
    end

    // Build the boolean incidence matrix
    always_comb begin
        m1 = '0;
        for (int a = 0; a < NUM_LETTERS; a++) begin
            for (int r = 0; r < IMG_LEN; r++) begin
                m1[img[a][r]][a] = 1'b1;
            end
        end
    end

    // Raise to the twelfth power by squaring. Every column of M is non-empty,
    // so once a power is all positive every later one is too; checking the
    // twelfth power alone therefore covers powers one to twelve.
    always_comb begin
        m2  = mat_mul(m1, m1);
        m4  = mat_mul(m2, m2);
        m8  = mat_mul(m4, m4);
        m12 = mat_mul(m8, m4);
    end

    assign o_result.prolongable   = prol;
    assign o_result.distinct_sums = count;
    assign o_result.primitive_res = &m12;

endmodule

### test/tb_morphism_code_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morphism_code_filter_core
// Self-checking bench for the morphism code filter. Codes are fed through the
// valid/ready input channel from a queue of pending codes, and each result
// transaction is checked against a behavioural evaluation of the same code:
// prolongable flag, distinct image-sum count, primitivity of the boolean
// incidence matrix and the combined flag against the threshold in force. The
// threshold is rewritten between phases, across the reachable counts and beyond them.
// ----------------------------------------------------------------------------
module tb_morphism_code_filter_core;
    import mcf_pkg::*;

    localparam int MAX_POWER     = 12;
    localparam int PHASE_ITEMS   = 170;
    localparam int HOLD_AT_COUNT = 300;
    localparam int HOLD_CYCLES   = 80;

    // Expected outcome of one code
    typedef struct {
        logic   prolongable;
        t_count distinct_sums;
        logic   primitive_res;
        logic   passes_all;
    } t_verdict;

    logic    i_clk                   = 1'b0;
    logic    i_rst_n                 = 1'b0;
    logic    i_cfg_valid             = 1'b0;
    logic    o_cfg_ready;
    t_thresh i_cfg_min_distinct_sums = '0;
    logic    i_in_valid              = 1'b0;
    logic    o_in_ready;
    t_code   i_morphism_code         = '0;
    logic    o_out_valid;
    logic    i_out_ready             = 1'b0;
    logic    o_prolongable;
    t_count  o_distinct_sums;
    logic    o_primitive_res;
    logic    o_passes_all;

    t_thresh     thresh_model = THRESH_RESET;
    t_code       pending_codes[$];
    t_verdict    verdict_q[$];
    int unsigned n_accepted   = 0;
    int unsigned n_queued     = 0;
    int unsigned n_checked    = 0;
    int unsigned n_fail       = 0;
    int unsigned in_gap       = 0;
    int unsigned out_gap      = 0;
    logic        idle_en      = 1'b1;
    logic        hold_off     = 1'b0;

    always #5 i_clk = ~i_clk;

    morphism_code_filter_core uut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_min_distinct_sums (i_cfg_min_distinct_sums),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_morphism_code         (i_morphism_code),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_prolongable           (o_prolongable),
        .o_distinct_sums         (o_distinct_sums),
        .o_primitive_res         (o_primitive_res),
        .o_passes_all            (o_passes_all)
    );

    // Evaluate one code: images, sums, incidence matrix and its powers
    function automatic t_verdict evaluate_morphism(input t_code code, input t_thresh thresh);
        t_letter                img   [NUM_LETTERS][IMG_LEN];
        logic [NUM_LETTERS-1:0] inc   [NUM_LETTERS];
        logic [NUM_LETTERS-1:0] reach [NUM_LETTERS];
        logic [NUM_LETTERS-1:0] nxt   [NUM_LETTERS];
        logic [9:0]             seen;
        logic                   full;
        int                     s;
        t_verdict               v;
        seen            = '0;
        v.prolongable   = 1'b0;
        v.distinct_sums = '0;
        v.primitive_res = 1'b0;
        for (int a = 0; a < NUM_LETTERS; a++) begin
            inc[a] = '0;
        end
        for (int a = 0; a < NUM_LETTERS; a++) begin
            for (int r = 0; r < IMG_LEN; r++) begin
                img[a][r] = code[(a * IMG_LEN + r) * LETTER_W +: LETTER_W];
                inc[img[a][r]][a] = 1'b1;
            end
            if (img[a][0] == t_letter'(a)) begin
                v.prolongable = 1'b1;
            end
            s = int'(img[a][0]) + int'(img[a][1]) + int'(img[a][2]);
            if (!seen[s]) begin
                seen[s]         = 1'b1;
                v.distinct_sums = v.distinct_sums + t_count'(1);
            end
        end
        // Walk the powers on the boolean pattern until one is all ones
        for (int i = 0; i < NUM_LETTERS; i++) begin
            reach[i] = inc[i];
        end
        for (int p = 1; p <= MAX_POWER; p++) begin
            full = 1'b1;
            for (int i = 0; i < NUM_LETTERS; i++) begin
                if (reach[i] != '1) begin
                    full = 1'b0;
                end
            end
            if (full) begin
                v.primitive_res = 1'b1;
                break;
            end
            for (int i = 0; i < NUM_LETTERS; i++) begin
                nxt[i] = '0;
                for (int k = 0; k < NUM_LETTERS; k++) begin
                    if (reach[i][k]) begin
                        nxt[i] = nxt[i] | inc[k];
                    end
                end
            end
            for (int i = 0; i < NUM_LETTERS; i++) begin
                reach[i] = nxt[i];
            end
        end
        v.passes_all = v.prolongable && v.primitive_res && (v.distinct_sums >= thresh);
        return v;
    endfunction

    // Build a code from twelve image letters, letter 0's image first
    function automatic t_code morphism_of(input string word);
        t_code c;
        c = '0;
        for (int i = 0; i < NUM_LETTERS * IMG_LEN; i++) begin
            c[i * LETTER_W +: LETTER_W] = t_letter'(word[i] - 8'h30);
        end
        return c;
    endfunction

    // Random code: half uniform, the rest forced prolongable or with a repeated image
    function automatic t_code random_code();
        t_code       c;
        int unsigned a;
        int unsigned b;
        int unsigned mode;
        c    = t_code'($urandom);
        mode = $urandom_range(0, 9);
        a    = $urandom_range(0, NUM_LETTERS - 1);
        b    = $urandom_range(0, NUM_LETTERS - 1);
        if (mode < 4) begin
            c[a * IMG_LEN * LETTER_W +: LETTER_W] = t_letter'(a);
        end else if (mode < 5) begin
            c[b * IMG_LEN * LETTER_W +: IMG_LEN * LETTER_W] =
                c[a * IMG_LEN * LETTER_W +: IMG_LEN * LETTER_W];
        end
        return c;
    endfunction

    // Append a code to the pending queue and count it as owed a result
    task automatic enqueue_code(input t_code code);
        pending_codes.insert(pending_codes.size(), code);
        n_queued++;
    endtask

    // Hold until every queued code has had its result transaction checked
    task automatic wait_drained();
        while (n_checked < n_queued) begin
            @(posedge i_clk);
        end
    endtask

    // Write the threshold register and track it once the transaction completes
    task automatic write_threshold(input t_thresh value);
        @(posedge i_clk);
        i_cfg_valid             <= 1'b1;
        i_cfg_min_distinct_sums <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        thresh_model = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Code driver: hold a stalled transaction, else idle or send the next code
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdict_q.insert(verdict_q.size(),
                                 evaluate_morphism(i_morphism_code, thresh_model));
                n_accepted <= n_accepted + 1;
            end
            if (i_in_valid && !o_in_ready) begin
                // keep the offered code until it is taken
            end else if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_codes.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
                in_gap     <= $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else if (pending_codes.size() != 0) begin
                i_in_valid      <= 1'b1;
                i_morphism_code <= pending_codes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold-off on request, else random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            out_gap     <= $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result with no code outstanding: prolongable %0d sums %0d",
                       o_prolongable, o_distinct_sums);
                n_fail++;
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (o_prolongable !== want.prolongable) begin
                    $error("prolongable: expected %0d, actual %0d",
                           want.prolongable, o_prolongable);
                    n_fail++;
                end
                if (o_distinct_sums !== want.distinct_sums) begin
                    $error("distinct_sums: expected %0d, actual %0d",
                           want.distinct_sums, o_distinct_sums);
                    n_fail++;
                end
                if (o_primitive_res !== want.primitive_res) begin
                    $error("primitive_res: expected %0d, actual %0d",
                           want.primitive_res, o_primitive_res);
                    n_fail++;
                end
                if (o_passes_all !== want.passes_all) begin
                    $error("passes_all: expected %0d, actual %0d",
                           want.passes_all, o_passes_all);
                    n_fail++;
                end
            end
        end
    end

    // Stall the receiver for a long stretch so the pipeline fills and backs up
    initial begin : receiver_hold
        while (n_accepted < HOLD_AT_COUNT) begin
            @(posedge i_clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Stimulus: directed codes at the reset threshold, then random phases
    initial begin : stimulus
        t_thresh phase_thresh [9];
        phase_thresh = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd5, 3'd2, 3'd6, 3'd1, 3'd3};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, single bits at either end and alternating bit patterns
        enqueue_code(24'h000000);
        enqueue_code(24'hFFFFFF);
        enqueue_code(24'h000001);
        enqueue_code(24'h800000);
        enqueue_code(24'h555555);
        enqueue_code(24'hAAAAAA);
        // Prolongable, primitive, four distinct sums
        enqueue_code(morphism_of("012123230301"));
        // Primitive but no image starts with its own letter
        enqueue_code(morphism_of("123230301012"));
        // Diagonal matrix: prolongable everywhere, never primitive
        enqueue_code(morphism_of("000111222333"));
        // Pure cycle: powers stay permutations
        enqueue_code(morphism_of("111222333000"));
        // Two letters never reached
        enqueue_code(morphism_of("010101010101"));
        // Two letters each reached only from itself
        enqueue_code(morphism_of("001100200300"));
        // Cycle plus a chord: needs the tenth power
        enqueue_code(morphism_of("111222333001"));
        // Prolongable through the last letter only
        enqueue_code(morphism_of("111222333300"));
        // Two swapped pairs
        enqueue_code(morphism_of("333222111000"));
        enqueue_code(morphism_of("210321032103"));
        wait_drained();

        // Random phases; threshold includes values outside 1 to 4
        for (int ph = 0; ph < 9; ph++) begin
            write_threshold(phase_thresh[ph]);
            idle_en <= (ph != 1 && ph != 8);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                enqueue_code(random_code());
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
